/* rtl/jpeg_header_dimension_scanner_unit_assert.svh */
// Assertion macros for the JPEG header dimension scanner.
`ifndef JPEG_HEADER_DIMENSION_SCANNER_UNIT_ASSERT_SVH
`define JPEG_HEADER_DIMENSION_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define JHDS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jhds: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define JHDS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jhds: next-cycle check failed");

`endif

/* rtl/jhds_pkg.sv */
// Package: types, marker codes and helpers for the JPEG header dimension scanner.
`timescale 1ns / 1ps
package jhds_pkg;

    localparam logic [7:0] MK_FILL  = 8'hFF;
    localparam logic [7:0] MK_SOI   = 8'hD8;
    localparam logic [7:0] MK_EOI   = 8'hD9;
    localparam logic [7:0] MK_SOS   = 8'hDA;
    localparam logic [7:0] MK_TEM   = 8'h01;
    localparam logic [7:0] MK_RST0  = 8'hD0;
    localparam logic [7:0] MK_RST7  = 8'hD7;
    localparam logic [7:0] MK_SOF0  = 8'hC0;
    localparam logic [7:0] MK_SOF15 = 8'hCF;
    localparam logic [7:0] MK_DHT   = 8'hC4;
    localparam logic [7:0] MK_JPG   = 8'hC8;
    localparam logic [7:0] MK_DAC   = 8'hCC;
    localparam logic [7:0] MK_SOF2  = 8'hC2;
    localparam logic [7:0] MK_SOF10 = 8'hCA;

    // Frame header bytes counted, and how many of them are kept.
    localparam int FRAME_HDR_BYTES = 6;
    localparam int FRAME_KEEP      = 5;

    typedef enum logic [3:0] {
        PH_START0,
        PH_START1,
        PH_SEEK,
        PH_MARKER,
        PH_LENHI,
        PH_LENLO,
        PH_SKIP,
        PH_FRAME,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        CAUSE_FRAME,
        CAUSE_END_MARKER,
        CAUSE_SHORT_LEN,
        CAUSE_EOF,
        CAUSE_BAD_START
    } cause_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic        start_marker_ok;
        logic        has_frame_info;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [7:0]  sample_precision;
        logic        is_progressive;
        cause_t      end_cause;
    } scan_result_t;

    function automatic logic is_frame_marker(input logic [7:0] m);
        return (m >= MK_SOF0) && (m <= MK_SOF15) && (m != MK_DHT) && (m != MK_JPG)
            && (m != MK_DAC);
    endfunction

    function automatic logic is_standalone(input logic [7:0] m);
        return ((m >= MK_RST0) && (m <= MK_RST7)) || (m == MK_TEM);
    endfunction

endpackage

/* rtl/jhds_input_stage.sv */
// Input register: holds one byte transaction until the parser takes it.
`timescale 1ns / 1ps
module jhds_input_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  jhds_pkg::byte_item_t item_in,
    input  logic                advance,
    output logic                item_valid,
    output jhds_pkg::byte_item_t item_out
);
    import jhds_pkg::*;

    logic       vld_reg;
    logic       vld_next;
    byte_item_t item_reg;
    logic       take;

    assign byte_stall = vld_reg && !advance;
    assign take       = byte_valid && !byte_stall;

    always_comb
    begin
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = vld_reg;
    assign item_out   = item_reg;

endmodule

/* rtl/jhds_parser.sv */
// Marker parser: per-byte state update and summary result for one file.
`timescale 1ns / 1ps
`include "jpeg_header_dimension_scanner_unit_assert.svh"
module jhds_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  jhds_pkg::byte_item_t  item,
    output logic                  emit,
    output jhds_pkg::scan_result_t result
);
    import jhds_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [7:0]  marker_reg, marker_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] skip_reg,   skip_next;
    logic [2:0]  idx_reg,    idx_next;
    logic        start_ok_reg, start_ok_next;
    logic [7:0]  frame_bytes_reg [FRAME_KEEP];

    logic        hit;
    cause_t      hit_cause;
    logic        frame_done;
    logic        start_ok_upd;
    logic        live;
    logic        fb_wr;
    logic [15:0] seg;
    logic [15:0] seg_m2;
    logic [7:0]  b;

    assign b      = item.data_byte;
    assign seg    = {len_hi_reg, b};
    assign seg_m2 = seg - 16'd2;

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        marker_next   = marker_reg;
        len_hi_next   = len_hi_reg;
        skip_next     = skip_reg;
        idx_next      = idx_reg;
        start_ok_upd  = start_ok_reg;
        hit           = 1'b0;
        hit_cause     = CAUSE_FRAME;
        frame_done    = 1'b0;
        live          = 1'b1;
        case (phase_reg)
            PH_START0:
            begin
                if (b == MK_FILL)
                begin
                    phase_next = PH_START1;
                end
                else
                begin
                    hit       = 1'b1;
                    hit_cause = CAUSE_BAD_START;
                end
            end
            PH_START1:
            begin
                if (b == MK_SOI)
                begin
                    start_ok_upd = 1'b1;
                    phase_next   = PH_SEEK;
                end
                else
                begin
                    hit       = 1'b1;
                    hit_cause = CAUSE_BAD_START;
                end
            end
            PH_SEEK:
            begin
                if (b == MK_FILL)
                begin
                    phase_next = PH_MARKER;
                end
            end
            PH_MARKER:
            begin
                if (b == MK_FILL)
                begin
                    phase_next = PH_MARKER;
                end
                else if ((b == MK_EOI) || (b == MK_SOS))
                begin
                    hit       = 1'b1;
                    hit_cause = CAUSE_END_MARKER;
                end
                else if (is_standalone(b))
                begin
                    phase_next = PH_SEEK;
                end
                else
                begin
                    marker_next = b;
                    phase_next  = PH_LENHI;
                end
            end
            PH_LENHI:
            begin
                len_hi_next = b;
                phase_next  = PH_LENLO;
            end
            PH_LENLO:
            begin
                if (seg < 16'd2)
                begin
                    hit       = 1'b1;
                    hit_cause = CAUSE_SHORT_LEN;
                end
                else if (is_frame_marker(marker_reg))
                begin
                    if (seg_m2 >= 16'(FRAME_HDR_BYTES))
                    begin
                        idx_next   = 3'd0;
                        phase_next = PH_FRAME;
                    end
                    else
                    begin
                        hit       = 1'b1;
                        hit_cause = CAUSE_FRAME;
                    end
                end
                else if (seg_m2 == 16'd0)
                begin
                    phase_next = PH_SEEK;
                end
                else
                begin
                    skip_next  = seg_m2;
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_reg - 16'd1;
                if (skip_next == 16'd0)
                begin
                    phase_next = PH_SEEK;
                end
            end
            PH_FRAME:
            begin
                idx_next = idx_reg + 3'd1;
                if (idx_next == 3'(FRAME_HDR_BYTES))
                begin
                    frame_done = 1'b1;
                    hit        = 1'b1;
                    hit_cause  = CAUSE_FRAME;
                end
            end
            default:
            begin
                live = 1'b0;
            end
        endcase

        start_ok_next = start_ok_upd;
        if (item.last_byte)
        begin
            phase_next    = PH_START0;
            marker_next   = 8'd0;
            len_hi_next   = 8'd0;
            skip_next     = 16'd0;
            idx_next      = 3'd0;
            start_ok_next = 1'b0;
        end
        else if (live && hit)
        begin
            phase_next = PH_DONE;
        end
    end

    // result fields
    always_comb
    begin
        emit                   = go && live && (hit || item.last_byte);
        result.start_marker_ok = start_ok_upd;
        result.has_frame_info  = frame_done;
        if (frame_done)
        begin
            result.image_width      = {frame_bytes_reg[3], frame_bytes_reg[4]};
            result.image_height     = {frame_bytes_reg[1], frame_bytes_reg[2]};
            result.sample_precision = frame_bytes_reg[0];
            result.is_progressive   = (marker_reg == MK_SOF2) || (marker_reg == MK_SOF10);
        end
        else
        begin
            result.image_width      = 16'd0;
            result.image_height     = 16'd0;
            result.sample_precision = 8'd0;
            result.is_progressive   = 1'b0;
        end
        if (hit)
        begin
            result.end_cause = hit_cause;
        end
        else if (start_ok_upd)
        begin
            result.end_cause = CAUSE_EOF;
        end
        else
        begin
            result.end_cause = CAUSE_BAD_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START0;
            marker_reg   <= 8'd0;
            len_hi_reg   <= 8'd0;
            skip_reg     <= 16'd0;
            idx_reg      <= 3'd0;
            start_ok_reg <= 1'b0;
        end
        else if (go)
        begin
            phase_reg    <= phase_next;
            marker_reg   <= marker_next;
            len_hi_reg   <= len_hi_next;
            skip_reg     <= skip_next;
            idx_reg      <= idx_next;
            start_ok_reg <= start_ok_next;
        end
    end

    // precision, height and width bytes; the component count is not kept
    assign fb_wr = go && (phase_reg == PH_FRAME) && (idx_reg < 3'(FRAME_KEEP));

    always_ff @(posedge clk)
    begin
        if (fb_wr)
        begin
            frame_bytes_reg[idx_reg] <= b;
        end
    end

    `JHDS_ASSERT_NEXT(a_end_parks, go && emit && !item.last_byte, phase_reg == PH_DONE)
    `JHDS_ASSERT_NEXT(a_last_clears, go && item.last_byte,
        (phase_reg == PH_START0) && !start_ok_reg)
    `JHDS_ASSERT_NOW(a_skip_nonzero, phase_reg == PH_SKIP, skip_reg != 16'd0)
    `JHDS_ASSERT_NOW(a_frame_idx, phase_reg == PH_FRAME, idx_reg < 3'(FRAME_HDR_BYTES))
    `JHDS_ASSERT_NOW(a_frame_cause, emit && result.has_frame_info,
        result.end_cause == CAUSE_FRAME && result.start_marker_ok)

endmodule

/* rtl/jhds_result_reg.sv */
// Result register: holds one summary transaction until the consumer takes it.
`timescale 1ns / 1ps
module jhds_result_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  jhds_pkg::scan_result_t result_in,
    input  logic                  result_stall,
    output logic                  result_valid,
    output logic                  advance,
    output jhds_pkg::scan_result_t result_out
);
    import jhds_pkg::*;

    logic         vld_reg;
    logic         vld_next;
    scan_result_t res_reg;

    assign advance = !vld_reg || !result_stall;

    always_comb
    begin
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (!result_stall)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result_in;
        end
    end

    assign result_valid = vld_reg;
    assign result_out   = res_reg;

endmodule

/* rtl/jpeg_header_dimension_scanner_unit.sv */
// Throughput is one byte per clock while the consumer does not stall: each byte is registered
// at the input, then updates the parser state and, when it ends the scan, loads the result
// register, which offers the result. The result register is the only back-pressure point; a
// byte is held while a finished result waits and the consumer stalls.
// One result is given per file; bytes after the scan ends are dropped until the last byte.
`timescale 1ns / 1ps
module jpeg_header_dimension_scanner_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        byte_valid,
    output logic        byte_stall,
    output logic        start_marker_ok,
    output logic        has_frame_info,
    output logic [15:0] image_width,
    output logic [15:0] image_height,
    output logic [7:0]  sample_precision,
    output logic        is_progressive,
    output logic [2:0]  end_cause,
    output logic        result_valid,
    input  logic        result_stall
);
    import jhds_pkg::*;

    byte_item_t   item_in;
    byte_item_t   item_q;
    logic         item_valid;
    logic         advance;
    logic         go;
    logic         emit;
    scan_result_t result_d;
    scan_result_t result_q;

    assign item_in.data_byte = data_byte;
    assign item_in.last_byte = last_byte;
    assign go = item_valid && advance;

    jhds_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .item_in    (item_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item_out   (item_q)
    );

    jhds_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .item   (item_q),
        .emit   (emit),
        .result (result_d)
    );

    jhds_result_reg u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (emit),
        .result_in    (result_d),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .advance      (advance),
        .result_out   (result_q)
    );

    assign start_marker_ok  = result_q.start_marker_ok;
    assign has_frame_info   = result_q.has_frame_info;
    assign image_width      = result_q.image_width;
    assign image_height     = result_q.image_height;
    assign sample_precision = result_q.sample_precision;
    assign is_progressive   = result_q.is_progressive;
    assign end_cause        = result_q.end_cause;

endmodule
